// ----- src/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int FX_W        = FRAC_BITS + 1;
   localparam int HUE_W       = 13;
   localparam int REM_W       = 10;
   localparam int SEC_W       = 3;
   localparam int HUE_FULL    = 5760;
   localparam int HUE_SECTOR  = 960;
   localparam int NUM_SECTORS = 6;

   localparam int PROD_W = FX_W + REM_W;
   localparam int MUL_W  = 2 * FX_W;

   // divide by 960 as a shift by 6 and a reciprocal multiply by 1/15
   localparam int DIV_SHIFT = 6;
   localparam int DIV_ODD   = 15;
   localparam int Y_W       = PROD_W - DIV_SHIFT;
   localparam int DIV_K     = Y_W + 4;
   localparam int RECIP_W   = DIV_K - 3;
   localparam int EST_W     = Y_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << DIV_K) / 64'(DIV_ODD));

   localparam logic [FX_W-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic [SEC_W-1:0] SEC_RY = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YG = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GC = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CB = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BM = 3'd4;
   localparam logic [SEC_W-1:0] SEC_MR = 3'd5;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [FX_W-1:0]  saturation;
      logic [FX_W-1:0]  brightness;
   } req_type;

   typedef struct packed {
      logic [FX_W-1:0] red;
      logic [FX_W-1:0] green;
      logic [FX_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             gray;
      logic [SEC_W-1:0] sector;
   } ctl_type;

endpackage

// ----- src/hsv2rgb_front.sv -----
module hsv2rgb_front
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   output ctl_type           ctl,
   output logic [FX_W-1:0]   val,
   output logic [MUL_W-1:0]  p_prod,
   output logic [PROD_W-1:0] f_prod,
   output logic [PROD_W-1:0] g_prod
);

   function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_W-1:0] sec_sel);
      logic [HUE_W-1:0] base;
      case (sec_sel)
         SEC_RY:  base = HUE_W'(0);
         SEC_YG:  base = HUE_W'(HUE_SECTOR);
         SEC_GC:  base = HUE_W'(2 * HUE_SECTOR);
         SEC_CB:  base = HUE_W'(3 * HUE_SECTOR);
         SEC_BM:  base = HUE_W'(4 * HUE_SECTOR);
         SEC_MR:  base = HUE_W'(5 * HUE_SECTOR);
         default: base = HUE_W'(0);
      endcase
      return base;
   endfunction

   logic [HUE_W-1:0]  hue_wrap;
   logic [SEC_W-1:0]  sec;
   ctl_type           ctl_a_in, ctl_a_ff, ctl_b_ff;
   logic [FX_W-1:0]   sat_a_in, sat_a_ff;
   logic [FX_W-1:0]   val_a_in, val_a_ff, val_b_ff;
   logic [REM_W-1:0]  rem_a_in, rem_a_ff;
   logic [REM_W-1:0]  rest;
   logic [MUL_W-1:0]  p_prod_in, p_prod_ff;
   logic [PROD_W-1:0] f_prod_in, f_prod_ff;
   logic [PROD_W-1:0] g_prod_in, g_prod_ff;

   // stage a: clamp, hue wrap, sector split
   always_comb begin
      hue_wrap = (req.hue >= HUE_W'(HUE_FULL)) ? '0 : req.hue;
      sec = SEC_RY;
      for (int k = 1; k < NUM_SECTORS; k++) begin
         if (hue_wrap >= HUE_W'(k * HUE_SECTOR)) begin
            sec = SEC_W'(k);
         end
      end
      rem_a_in = REM_W'(hue_wrap - sector_base(sec));
      sat_a_in = (req.saturation > FX_ONE) ? FX_ONE : req.saturation;
      val_a_in = (req.brightness > FX_ONE) ? FX_ONE : req.brightness;
      ctl_a_in.valid  = accept;
      ctl_a_in.gray   = (req.saturation == '0);
      ctl_a_in.sector = sec;
   end

   // stage b: products
   always_comb begin
      rest      = REM_W'(HUE_SECTOR) - rem_a_ff;
      f_prod_in = PROD_W'(sat_a_ff) * PROD_W'(rem_a_ff);
      g_prod_in = PROD_W'(sat_a_ff) * PROD_W'(rest);
      p_prod_in = MUL_W'(val_a_ff) * MUL_W'(FX_ONE - sat_a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else begin
         ctl_a_ff <= ctl_a_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      sat_a_ff  <= sat_a_in;
      val_a_ff  <= val_a_in;
      rem_a_ff  <= rem_a_in;
      val_b_ff  <= val_a_ff;
      p_prod_ff <= p_prod_in;
      f_prod_ff <= f_prod_in;
      g_prod_ff <= g_prod_in;
   end

   assign ctl    = ctl_b_ff;
   assign val    = val_b_ff;
   assign p_prod = p_prod_ff;
   assign f_prod = f_prod_ff;
   assign g_prod = g_prod_ff;

endmodule

// ----- src/hsv2rgb_div960.sv -----
module hsv2rgb_div960
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic [PROD_W-1:0] dividend,
   output logic [FX_W-1:0]   quotient
);

   logic [Y_W-1:0]   y_in, y_ff;
   logic [EST_W-1:0] est_prod;
   logic [Y_W-1:0]   est_in, est_ff;
   logic [Y_W+3:0]   back;
   logic [Y_W+3:0]   diff;
   logic             fix;
   logic [FX_W-1:0]  quo_in, quo_ff;

   // estimate is exact or one low
   always_comb begin
      y_in     = dividend[PROD_W-1:DIV_SHIFT];
      est_prod = EST_W'(y_in) * EST_W'(RECIP);
      est_in   = Y_W'(est_prod >> DIV_K);
   end

   always_comb begin
      back   = {est_ff, 4'b0000} - (Y_W+4)'(est_ff);
      diff   = (Y_W+4)'(y_ff) - back;
      fix    = (diff >= (Y_W+4)'(DIV_ODD));
      quo_in = FX_W'(est_ff + Y_W'(fix));
   end

   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      est_ff <= est_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

// ----- src/hsv2rgb_back.sv -----
module hsv2rgb_back
   import hsv2rgb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctl_type         ctl,
   input  logic [FX_W-1:0] val,
   input  logic [FX_W-1:0] p,
   input  logic [FX_W-1:0] sf,
   input  logic [FX_W-1:0] sg,
   output logic            out_valid,
   output rsp_type         out_data
);

   ctl_type          ctl_e_ff;
   logic [FX_W-1:0]  val_e_ff, p_e_ff;
   logic [MUL_W-1:0] q_prod, t_prod;
   logic [FX_W-1:0]  q_in, q_ff, t_in, t_ff;
   rsp_type          rsp_in, rsp_ff;
   logic             valid_ff;

   // stage e: q and t
   always_comb begin
      q_prod = MUL_W'(val) * MUL_W'(FX_ONE - sf);
      t_prod = MUL_W'(val) * MUL_W'(FX_ONE - sg);
      q_in   = FX_W'(q_prod >> FRAC_BITS);
      t_in   = FX_W'(t_prod >> FRAC_BITS);
   end

   // stage f: sector mux, gray override
   always_comb begin
      case (ctl_e_ff.sector)
         SEC_RY:  rsp_in = '{red: val_e_ff, green: t_ff,     blue: p_e_ff};
         SEC_YG:  rsp_in = '{red: q_ff,     green: val_e_ff, blue: p_e_ff};
         SEC_GC:  rsp_in = '{red: p_e_ff,   green: val_e_ff, blue: t_ff};
         SEC_CB:  rsp_in = '{red: p_e_ff,   green: q_ff,     blue: val_e_ff};
         SEC_BM:  rsp_in = '{red: t_ff,     green: p_e_ff,   blue: val_e_ff};
         default: rsp_in = '{red: val_e_ff, green: p_e_ff,   blue: q_ff};
      endcase
      if (ctl_e_ff.gray) begin
         rsp_in = '{red: val_e_ff, green: val_e_ff, blue: val_e_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_e_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         ctl_e_ff <= ctl;
         valid_ff <= ctl_e_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      val_e_ff <= val;
      p_e_ff   <= p;
      q_ff     <= q_in;
      t_ff     <= t_in;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ----- src/hsv_to_rgb_converter_unit.sv -----
// throughput: one item per cycle, busy is never raised
// six register stages: sector split, products, two divide-by-960 steps,
// q and t scaling, sector mux; the receiver cannot stall the pipeline
// reset: synchronous, active high, clears the valid bits of all stages
module hsv_to_rgb_converter_unit
   import hsv2rgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic              accept;
   ctl_type           ctl_b, ctl_c_ff, ctl_d_ff;
   logic [FX_W-1:0]   val_b, val_c_ff, val_d_ff;
   logic [MUL_W-1:0]  p_prod_b;
   logic [FX_W-1:0]   p_c_ff, p_d_ff;
   logic [PROD_W-1:0] f_prod_b, g_prod_b;
   logic [FX_W-1:0]   sf_d, sg_d;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   hsv2rgb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .ctl    (ctl_b),
      .val    (val_b),
      .p_prod (p_prod_b),
      .f_prod (f_prod_b),
      .g_prod (g_prod_b)
   );

   hsv2rgb_div960 u_div_f (
      .clock    (clock),
      .dividend (f_prod_b),
      .quotient (sf_d)
   );

   hsv2rgb_div960 u_div_g (
      .clock    (clock),
      .dividend (g_prod_b),
      .quotient (sg_d)
   );

   // side band alongside the divide stages
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_c_ff <= '0;
         ctl_d_ff <= '0;
      end else begin
         ctl_c_ff <= ctl_b;
         ctl_d_ff <= ctl_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_c_ff <= val_b;
      val_d_ff <= val_c_ff;
      p_c_ff   <= FX_W'(p_prod_b >> FRAC_BITS);
      p_d_ff   <= p_c_ff;
   end

   hsv2rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_d_ff),
      .val       (val_d_ff),
      .p         (p_d_ff),
      .sf        (sf_d),
      .sg        (sg_d),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_valid_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 6))
      else $error("result item without a started item");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.red <= FX_ONE && rsp_data.green <= FX_ONE &&
                     rsp_data.blue <= FX_ONE))
      else $error("result channel above one");

   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_data.saturation, 6) == '0) |->
         (rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue))
      else $error("zero saturation item not gray");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
   import hsv2rgb_pkg::*;
();

   class color_scoreboard;
      req_type     pixel_q[$];
      rsp_type     rgb_q[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [63:0] clip_one(logic [FX_W-1:0] x);
         return (x > FX_ONE) ? 64'(FX_ONE) : 64'(x);
      endfunction

      function rsp_type hsv_to_rgb(req_type px);
         logic [63:0] hue_v, sat, val, sector, frac, sf, sg, p, q, t;
         rsp_type     rgb;
         hue_v = 64'(px.hue);
         sat   = clip_one(px.saturation);
         val   = clip_one(px.brightness);
         if (sat == 0) begin
            rgb.red   = FX_W'(val);
            rgb.green = FX_W'(val);
            rgb.blue  = FX_W'(val);
            return rgb;
         end
         if (hue_v >= HUE_FULL) begin
            hue_v = 0;
         end
         sector = hue_v / HUE_SECTOR;
         frac   = hue_v % HUE_SECTOR;
         sf = (sat * frac) / HUE_SECTOR;
         sg = (sat * (HUE_SECTOR - frac)) / HUE_SECTOR;
         p  = (val * (64'(FX_ONE) - sat)) >> FRAC_BITS;
         q  = (val * (64'(FX_ONE) - sf)) >> FRAC_BITS;
         t  = (val * (64'(FX_ONE) - sg)) >> FRAC_BITS;
         case (sector[SEC_W-1:0])
            SEC_RY: begin
               rgb.red = FX_W'(val); rgb.green = FX_W'(t); rgb.blue = FX_W'(p);
            end
            SEC_YG: begin
               rgb.red = FX_W'(q); rgb.green = FX_W'(val); rgb.blue = FX_W'(p);
            end
            SEC_GC: begin
               rgb.red = FX_W'(p); rgb.green = FX_W'(val); rgb.blue = FX_W'(t);
            end
            SEC_CB: begin
               rgb.red = FX_W'(p); rgb.green = FX_W'(q); rgb.blue = FX_W'(val);
            end
            SEC_BM: begin
               rgb.red = FX_W'(t); rgb.green = FX_W'(p); rgb.blue = FX_W'(val);
            end
            default: begin
               rgb.red = FX_W'(val); rgb.green = FX_W'(p); rgb.blue = FX_W'(q);
            end
         endcase
         return rgb;
      endfunction

      function void note_pixel(req_type px);
         pixel_q.push_back(px);
         rgb_q.push_back(hsv_to_rgb(px));
      endfunction

      function void check_rgb(rsp_type got);
         req_type px;
         rsp_type want;
         if (rgb_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected item: r %0d g %0d b %0d", got.red, got.green, got.blue);
            end
            return;
         end
         px   = pixel_q.pop_front();
         want = rgb_q.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: h %0d s %0d v %0d expected r %0d g %0d b %0d,",
                        px.hue, px.saturation, px.brightness, want.red, want.green, want.blue,
                        " got r %0d g %0d b %0d", got.red, got.green, got.blue);
            end
         end
      endfunction

      function int pending();
         return rgb_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   color_scoreboard board;
   bit              no_idle;

   hsv_to_rgb_converter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_pixel(req_data);
         end
         if (rsp_valid) begin
            board.check_rgb(rsp_data);
         end
      end
   end

   function automatic req_type pixel(int unsigned h, int unsigned s, int unsigned v);
      req_type px;
      px.hue        = HUE_W'(h);
      px.saturation = FX_W'(s);
      px.brightness = FX_W'(v);
      return px;
   endfunction

   function automatic int unsigned rand_fraction();
      case ($urandom_range(9))
         0: return 0;
         1: return 1 << FRAC_BITS;
         2: return $urandom_range((1 << FX_W) - 1, (1 << FRAC_BITS) + 1);
         3: return $urandom_range((1 << FX_W) - 1);
         default: return $urandom_range(1 << FRAC_BITS);
      endcase
   endfunction

   function automatic req_type rand_pixel();
      int unsigned h;
      if ($urandom_range(7) == 0) begin
         h = $urandom_range((1 << HUE_W) - 1, HUE_FULL);
      end else begin
         h = $urandom_range(HUE_FULL - 1);
      end
      return pixel(h, rand_fraction(), rand_fraction());
   endfunction

   task automatic idle_cycles();
      while (!no_idle && $urandom_range(99) < 38) begin
         start    <= 1'b0;
         req_data <= pixel($urandom, $urandom, $urandom);
         @(posedge clock);
      end
   endtask

   task automatic send_pixel(req_type px);
      idle_cycles();
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      req_type directed[$];
      board    = new();
      no_idle  = 1'b0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed = '{
         pixel(0, 65536, 65536),     pixel(959, 65536, 65536),
         pixel(960, 65536, 65536),   pixel(1919, 40000, 50000),
         pixel(1920, 50000, 60000),  pixel(2880, 20000, 65536),
         pixel(3840, 65535, 30000),  pixel(4800, 45000, 65535),
         pixel(5759, 65536, 65536),  pixel(5760, 30000, 60000),
         pixel(8191, 131071, 131071), pixel(100, 0, 12345),
         pixel(8191, 0, 131071),     pixel(480, 65537, 65536),
         pixel(480, 1, 65536),       pixel(2000, 65536, 0),
         pixel(0, 0, 0),             pixel(3000, 32768, 65535),
         pixel(4000, 65535, 1),      pixel(5000, 12345, 65536),
         pixel(7000, 50000, 40000),  pixel(1440, 98304, 70000)
      };
      foreach (directed[i]) begin
         send_pixel(directed[i]);
      end

      for (int i = 0; i < 750; i++) begin
         no_idle = (i >= 300 && i < 450);
         send_pixel(rand_pixel());
      end
      start <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("tb_top failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/hsv2rgb_pkg.sv
src/hsv2rgb_front.sv
src/hsv2rgb_div960.sv
src/hsv2rgb_back.sv
src/hsv_to_rgb_converter_unit.sv
test/tb_top.sv
